/* rtl/ued_pkg.sv */
// ----------------------------------------------------------------------------
// ued_pkg
// Shared types, constants and helper functions of the escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ued_pkg;

  // Field widths
  localparam int CharW        = 8;
  localparam int CpW          = 18;
  localparam int HexW         = 20;
  localparam int LimitW       = HexW + 1;
  localparam int DigitCntW    = 3;

  // Held character buffer: backslash, u, brace and up to six digits
  localparam int HeldDepth    = 9;
  localparam int HeldIdxW     = $clog2(HeldDepth);
  localparam int HeldCntW     = $clog2(HeldDepth + 1);

  localparam int FixedDigits    = 4;
  localparam int MaxBraceDigits = 5;
  localparam int CodeLimitDef   = 196608;

  // Character codes
  localparam logic [CharW-1:0] ChFirstLegal = 8'd32;
  localparam logic [CharW-1:0] ChLastLegal  = 8'd127;
  localparam logic [CharW-1:0] ChBackslash  = 8'h5C;
  localparam logic [CharW-1:0] ChU          = 8'h75;
  localparam logic [CharW-1:0] ChLBrace     = 8'h7B;
  localparam logic [CharW-1:0] ChRBrace     = 8'h7D;
  localparam logic [CharW-1:0] ChDigit0     = 8'd48;
  localparam logic [CharW-1:0] ChDigit9     = 8'd57;
  localparam logic [CharW-1:0] ChUpperA     = 8'd65;
  localparam logic [CharW-1:0] ChUpperF     = 8'd70;
  localparam logic [CharW-1:0] ChLowerA     = 8'd97;
  localparam logic [CharW-1:0] ChLowerF     = 8'd102;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BSLASH,
    PH_U,
    PH_DIGITS
  } phase_e;

  // What one character does to the escape in progress
  typedef enum logic [1:0] {
    OC_EMIT,     // one result, escape cleared
    OC_ABSORB,   // character held, no result
    OC_ABS_GB,   // character held, then all held characters given back
    OC_GB        // held characters given back, character handled again
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLAY,
    ST_REHANDLE
  } ctrl_state_e;

  typedef struct packed {
    logic in_ready;
    logic use_input;
    logic load;
    logic apply;
    logic drop_step;
    logic replay_emit;
    logic replay_end;
    logic emit_last;
  } ued_cmd_t;

  typedef struct packed {
    logic     in_valid;
    logic     out_free;
    logic     dropping;
    outcome_e outcome;
    logic     eval_last;
    logic     replay_at_end;
    logic     quiet_rehandle;
  } ued_status_t;

  function automatic logic is_hex(input logic [CharW-1:0] c);
    return (c >= ChDigit0 && c <= ChDigit9) ||
           (c >= ChUpperA && c <= ChUpperF) ||
           (c >= ChLowerA && c <= ChLowerF);
  endfunction

  // Letters have bit 6 set and low nibble 1..6
  function automatic logic [3:0] hex_val(input logic [CharW-1:0] c);
    return c[3:0] + (c[6] ? 4'd9 : 4'd0);
  endfunction

endpackage

`default_nettype wire

/* rtl/ued_if.sv */
// ----------------------------------------------------------------------------
// ued_if
// Valid/ready channels carrying string bytes in and code points out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ued_in_if import ued_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_in;
  logic             last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface ued_out_if import ued_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [CpW-1:0] code_point;
  logic           illegal_char;
  logic           last_of_run;

  modport source (output valid, output code_point, output illegal_char,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input illegal_char,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/unicode_escape_decoder_unit.sv */
// ----------------------------------------------------------------------------
// unicode_escape_decoder_unit
// Turns string bytes into code points, decoding backslash-u escapes.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one string byte per word with last_char marking the end of
//   the string; out_o carries code points, an illegal_char flag and
//   last_of_run on the final word caused by each input word.
//   cfg_we_i/cfg_wdata_i write escape_enable (reset value 1) while idle.
// Timing:
//   Results leave through a register, in the cycle after the one that
//   produces them. A byte that passes through, completes an escape or is
//   held in an open escape needs no extra step, so plain text moves at
//   one byte per cycle while the output is taken. A byte that breaks an
//   escape is followed by a replay of the n held characters (n up to 9,
//   the breaking byte included when the escape keeps it), then, if not
//   kept, by the breaking byte handled again; an end mark in an open escape
//   adds the same replay. Input ready is low during replay and rehandling.
// Reset:
//   Clears the parse state, drop mode and the output valid flag.
// Stall:
//   While a result waits untaken, the output word holds and input ready and
//   replay both pause; no result is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module unicode_escape_decoder_unit import ued_pkg::*; #(
  parameter int CODE_LIMIT = CodeLimitDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  ued_in_if.sink    in_i,
  ued_out_if.source out_o
);

  ued_cmd_t    cmd;
  ued_status_t status;

  ued_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  ued_datapath #(
    .CODE_LIMIT (CODE_LIMIT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire

/* rtl/ued_datapath.sv */
// ----------------------------------------------------------------------------
// ued_datapath
// Escape parse state, held character buffer, character classifier and the
// output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module ued_datapath import ued_pkg::*; #(
  parameter int CODE_LIMIT = CodeLimitDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  ued_in_if.sink      in_i,
  ued_out_if.source   out_o,
  input  ued_cmd_t    cmd_i,
  output ued_status_t status_o
);

  localparam logic [LimitW-1:0] Limit = LimitW'(CODE_LIMIT);

  logic                 esc_en_q;
  logic                 dropping_q;
  phase_e               phase_q;
  logic                 brace_q;
  logic [DigitCntW-1:0] cnt_q;
  logic [HexW-1:0]      hex_q;
  logic [CharW-1:0]     held_q [HeldDepth];
  logic [HeldCntW-1:0]  held_n_q;
  logic [HeldIdxW-1:0]  rd_idx_q;
  logic [CharW-1:0]     c_q;
  logic                 clast_q;
  logic                 out_valid_q;
  logic [CpW-1:0]       out_cp_q;
  logic                 out_err_q;
  logic                 out_last_q;

  logic [CharW-1:0]     ev_c;
  logic                 ev_last;
  logic                 ch_legal;
  logic                 ch_hex;
  logic [3:0]           dig;
  logic [DigitCntW-1:0] cnt_inc;
  logic [HexW-1:0]      hex_new;
  logic                 close_ok;
  logic                 fixed_ok;
  logic                 take_digit;
  logic                 out_free;
  logic                 push;
  outcome_e             outcome;
  phase_e               phase_nx;
  logic                 brace_nx;
  logic [CpW-1:0]       emit_cp;
  logic                 emit_err;

  // Classify the character under evaluation
  assign ev_c     = cmd_i.use_input ? in_i.char_in : c_q;
  assign ev_last  = cmd_i.use_input ? in_i.last_char : clast_q;
  assign ch_legal = (ev_c >= ChFirstLegal) && (ev_c <= ChLastLegal);
  assign ch_hex   = is_hex(ev_c);
  assign dig      = hex_val(ev_c);
  assign cnt_inc  = cnt_q + DigitCntW'(1);
  assign hex_new  = (cnt_q < DigitCntW'(MaxBraceDigits)) ? {hex_q[HexW-5:0], dig} : hex_q;
  assign close_ok = brace_q && (cnt_q != '0) && ({1'b0, hex_q} < Limit);
  assign fixed_ok = {1'b0, hex_new} < Limit;
  assign take_digit = ((phase_q == PH_U) || (phase_q == PH_DIGITS)) && ch_hex;
  assign out_free = !out_valid_q || out_o.ready;

  // Decide what the character does to the escape
  always_comb begin
    outcome  = OC_EMIT;
    phase_nx = phase_q;
    brace_nx = brace_q;
    emit_cp  = CpW'(ev_c);
    emit_err = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (!ch_legal) begin
          emit_cp  = '0;
          emit_err = 1'b1;
        end else if ((ev_c == ChBackslash) && esc_en_q) begin
          outcome  = OC_ABSORB;
          phase_nx = PH_BSLASH;
        end
      end
      PH_BSLASH: begin
        if (ev_c == ChU) begin
          outcome  = OC_ABSORB;
          phase_nx = PH_U;
        end else begin
          outcome = OC_GB;
        end
      end
      PH_U: begin
        if (ev_c == ChLBrace) begin
          outcome  = OC_ABSORB;
          brace_nx = 1'b1;
          phase_nx = PH_DIGITS;
        end else if (ch_hex) begin
          outcome  = OC_ABSORB;
          phase_nx = PH_DIGITS;
        end else begin
          outcome = OC_GB;
        end
      end
      PH_DIGITS: begin
        if (ev_c == ChRBrace) begin
          if (close_ok) begin
            emit_cp = hex_q[CpW-1:0];
          end else begin
            outcome = OC_ABS_GB;
          end
        end else if (!ch_hex) begin
          outcome = OC_GB;
        end else if (!brace_q && (cnt_inc == DigitCntW'(FixedDigits))) begin
          if (fixed_ok) begin
            emit_cp = hex_new[CpW-1:0];
          end else begin
            outcome = OC_ABS_GB;
          end
        end else if (brace_q && (cnt_inc > DigitCntW'(MaxBraceDigits))) begin
          outcome = OC_ABS_GB;
        end else begin
          outcome = OC_ABSORB;
        end
      end
      default: outcome = OC_EMIT;
    endcase
  end

  assign push = cmd_i.apply && ((outcome == OC_ABSORB) || (outcome == OC_ABS_GB));

  // Advance the escape parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      brace_q  <= 1'b0;
      cnt_q    <= '0;
      hex_q    <= '0;
      held_n_q <= '0;
      rd_idx_q <= '0;
    end else begin
      if (cmd_i.apply) begin
        unique case (outcome)
          OC_EMIT: begin
            phase_q  <= PH_IDLE;
            brace_q  <= 1'b0;
            cnt_q    <= '0;
            hex_q    <= '0;
            held_n_q <= '0;
          end
          OC_ABSORB: begin
            phase_q  <= phase_nx;
            brace_q  <= brace_nx;
            held_n_q <= held_n_q + HeldCntW'(1);
            if (take_digit) begin
              cnt_q <= cnt_inc;
              hex_q <= hex_new;
            end
          end
          OC_ABS_GB: held_n_q <= held_n_q + HeldCntW'(1);
          OC_GB:     held_n_q <= held_n_q;
          default:   held_n_q <= held_n_q;
        endcase
      end else if (cmd_i.replay_end) begin
        phase_q  <= PH_IDLE;
        brace_q  <= 1'b0;
        cnt_q    <= '0;
        hex_q    <= '0;
        held_n_q <= '0;
      end
      if (cmd_i.replay_emit) begin
        rd_idx_q <= cmd_i.replay_end ? '0 : rd_idx_q + HeldIdxW'(1);
      end
    end
  end

  // Hold characters of the open escape
  always_ff @(posedge clk_i) begin
    if (push) begin
      held_q[held_n_q[HeldIdxW-1:0]] <= ev_c;
    end
  end

  // Configuration, drop mode and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_en_q    <= 1'b1;
      dropping_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        esc_en_q <= cfg_wdata_i;
      end
      if (cmd_i.apply && (outcome == OC_EMIT) && emit_err) begin
        dropping_q <= !ev_last;
      end else if (cmd_i.drop_step && in_i.last_char) begin
        dropping_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= (cmd_i.apply && (outcome == OC_EMIT)) || cmd_i.replay_emit;
      end
    end
  end

  // Latch the accepted word and load the output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_q     <= in_i.char_in;
      clast_q <= in_i.last_char;
    end
    if (out_free) begin
      if (cmd_i.apply && (outcome == OC_EMIT)) begin
        out_cp_q   <= emit_cp;
        out_err_q  <= emit_err;
        out_last_q <= 1'b1;
      end else if (cmd_i.replay_emit) begin
        out_cp_q   <= CpW'(held_q[rd_idx_q]);
        out_err_q  <= 1'b0;
        out_last_q <= cmd_i.emit_last;
      end
    end
  end

  assign in_i.ready         = cmd_i.in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.code_point   = out_cp_q;
  assign out_o.illegal_char = out_err_q;
  assign out_o.last_of_run  = out_last_q;

  assign status_o.in_valid       = in_i.valid;
  assign status_o.out_free       = out_free;
  assign status_o.dropping       = dropping_q;
  assign status_o.outcome        = outcome;
  assign status_o.eval_last      = ev_last;
  assign status_o.replay_at_end  = (HeldCntW'(rd_idx_q) + HeldCntW'(1)) == held_n_q;
  assign status_o.quiet_rehandle = (c_q == ChBackslash) && esc_en_q && !clast_q;

  // Checks
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_n_q <= HeldCntW'(HeldDepth))
    else $error("held buffer overfilled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> out_cp_q == '0)
    else $error("error word carries a nonzero code point");

  a_drop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropping_q |-> (phase_q == PH_IDLE) && (held_n_q == '0))
    else $error("dropping with an escape open");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (held_n_q == '0))
    else $error("held characters left with no escape open");

endmodule

`default_nettype wire

/* rtl/ued_ctrl.sv */
// ----------------------------------------------------------------------------
// ued_ctrl
// Sequencer: takes words, replays held characters of a broken escape and
// handles the breaking character again.
// ----------------------------------------------------------------------------
`default_nettype none

module ued_ctrl import ued_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ued_status_t status_i,
  output ued_cmd_t    cmd_o
);

  ctrl_state_e st_q, st_d;
  logic        reh_q, reh_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      reh_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      reh_q <= reh_d;
    end
  end

  // Next state
  always_comb begin
    st_d  = st_q;
    reh_d = reh_q;
    unique case (st_q)
      ST_IDLE: begin
        if (status_i.in_valid && status_i.out_free && !status_i.dropping) begin
          unique case (status_i.outcome)
            OC_EMIT: st_d = ST_IDLE;
            OC_ABSORB: begin
              if (status_i.eval_last) begin
                st_d  = ST_REPLAY;
                reh_d = 1'b0;
              end
            end
            OC_ABS_GB: begin
              st_d  = ST_REPLAY;
              reh_d = 1'b0;
            end
            OC_GB: begin
              st_d  = ST_REPLAY;
              reh_d = 1'b1;
            end
            default: st_d = ST_IDLE;
          endcase
        end
      end
      ST_REHANDLE: begin
        if (status_i.out_free) begin
          priority if ((status_i.outcome == OC_ABSORB) && status_i.eval_last) begin
            st_d  = ST_REPLAY;
            reh_d = 1'b0;
          end else begin
            st_d = ST_IDLE;
          end
        end
      end
      ST_REPLAY: begin
        if (status_i.out_free && status_i.replay_at_end) begin
          st_d = reh_q ? ST_REHANDLE : ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (st_q)
      ST_IDLE: begin
        cmd_o.in_ready  = status_i.out_free;
        cmd_o.use_input = 1'b1;
        if (status_i.in_valid && status_i.out_free) begin
          if (status_i.dropping) begin
            cmd_o.drop_step = 1'b1;
          end else begin
            cmd_o.load  = 1'b1;
            cmd_o.apply = 1'b1;
          end
        end
      end
      ST_REHANDLE: begin
        cmd_o.apply = status_i.out_free;
      end
      ST_REPLAY: begin
        if (status_i.out_free) begin
          cmd_o.replay_emit = 1'b1;
          cmd_o.replay_end  = status_i.replay_at_end;
          cmd_o.emit_last   = status_i.replay_at_end &&
                              (!reh_q || status_i.quiet_rehandle);
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire
